// ===== hdl/pnq_pkg.sv =====
package pnq_pkg;

  localparam int COEF_FRAC_BITS_DEF = 16;

  localparam int PIX_W      = 8;
  localparam int OUT_W      = 8;
  localparam int SCALE_W    = 17;
  localparam int BIAS_W     = 24;
  localparam int SHIFT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_CHAN   = 3;

  // Multiply, add bias, shift and fold sign, saturate.
  localparam int NUM_STAGES = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_CH0 = 3'd0,
    REG_SCALE_CH1 = 3'd1,
    REG_SCALE_CH2 = 3'd2,
    REG_BIAS_CH0  = 3'd3,
    REG_BIAS_CH1  = 3'd4,
    REG_BIAS_CH2  = 3'd5,
    REG_FRAC_SHIFT = 3'd6
  } cfg_reg_e;

  localparam logic [SCALE_W-1:0]       SCALE_CH0_RST  = 17'd1122;
  localparam logic [SCALE_W-1:0]       SCALE_CH1_RST  = 17'd1147;
  localparam logic [SCALE_W-1:0]       SCALE_CH2_RST  = 17'd1142;
  localparam logic signed [BIAS_W-1:0] BIAS_CH0_RST   = -24'sd138799;
  localparam logic signed [BIAS_W-1:0] BIAS_CH1_RST   = -24'sd133413;
  localparam logic signed [BIAS_W-1:0] BIAS_CH2_RST   = -24'sd118256;
  localparam logic [SHIFT_W-1:0]       FRAC_SHIFT_RST = 3'd0;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pnq_ctrl_t;

endpackage

// ===== hdl/pnq_pix_in_if.sv =====
interface pnq_pix_in_if;
  import pnq_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] chan0_in;
  logic [PIX_W-1:0] chan1_in;
  logic [PIX_W-1:0] chan2_in;

  modport source (output valid, chan0_in, chan1_in, chan2_in, input ready);
  modport sink   (input valid, chan0_in, chan1_in, chan2_in, output ready);
endinterface

// ===== hdl/pnq_pix_out_if.sv =====
interface pnq_pix_out_if;
  import pnq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] chan0_out;
  logic signed [OUT_W-1:0] chan1_out;
  logic signed [OUT_W-1:0] chan2_out;

  modport source (output valid, chan0_out, chan1_out, chan2_out, input ready);
  modport sink   (input valid, chan0_out, chan1_out, chan2_out, output ready);
endinterface

// ===== hdl/pixel_normalize_quantize_int8_core.sv =====
// Channel   Dir  Handshake     Payload
// pix_in    in   valid/ready   chan0_in, chan1_in, chan2_in (8 bit unsigned)
// pix_out   out  valid/ready   chan0_out, chan1_out, chan2_out (8 bit signed)
// cfg       in   cfg_we        cfg_index (3 bit), cfg_data (24 bit)
//
// Each request passes the pipeline stages multiply, bias add, shift with sign
// fold, saturate. One request enters per cycle while pix_in.ready is high.
// rst is synchronous; it empties the pipeline and loads the default coefficients.
// When pix_out stalls, stages fill up behind the output register and pix_in
// drops ready only once all four stages hold a request.
module pixel_normalize_quantize_int8_core #(
  parameter int COEF_FRAC_BITS = pnq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pnq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pnq_pkg::CFG_DATA_W-1:0] cfg_data,
  pnq_pix_in_if.sink                   pix_in,
  pnq_pix_out_if.source                pix_out
);
  import pnq_pkg::*;

  logic [SCALE_W-1:0]       scale [NUM_CHAN];
  logic signed [BIAS_W-1:0] bias  [NUM_CHAN];
  logic [SHIFT_W-1:0]       frac_shift;
  pnq_ctrl_t                ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale[0]   <= SCALE_CH0_RST;
      scale[1]   <= SCALE_CH1_RST;
      scale[2]   <= SCALE_CH2_RST;
      bias[0]    <= BIAS_CH0_RST;
      bias[1]    <= BIAS_CH1_RST;
      bias[2]    <= BIAS_CH2_RST;
      frac_shift <= FRAC_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_SCALE_CH0:  scale[0]   <= cfg_data[SCALE_W-1:0];
        REG_SCALE_CH1:  scale[1]   <= cfg_data[SCALE_W-1:0];
        REG_SCALE_CH2:  scale[2]   <= cfg_data[SCALE_W-1:0];
        REG_BIAS_CH0:   bias[0]    <= signed'(cfg_data[BIAS_W-1:0]);
        REG_BIAS_CH1:   bias[1]    <= signed'(cfg_data[BIAS_W-1:0]);
        REG_BIAS_CH2:   bias[2]    <= signed'(cfg_data[BIAS_W-1:0]);
        REG_FRAC_SHIFT: frac_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  pnq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .ctrl      (ctrl)
  );

  pnq_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane0 (
    .clk        (clk),
    .ctrl       (ctrl),
    .pix        (pix_in.chan0_in),
    .scale      (scale[0]),
    .bias       (bias[0]),
    .frac_shift (frac_shift),
    .q          (pix_out.chan0_out)
  );

  pnq_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane1 (
    .clk        (clk),
    .ctrl       (ctrl),
    .pix        (pix_in.chan1_in),
    .scale      (scale[1]),
    .bias       (bias[1]),
    .frac_shift (frac_shift),
    .q          (pix_out.chan1_out)
  );

  pnq_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane2 (
    .clk        (clk),
    .ctrl       (ctrl),
    .pix        (pix_in.chan2_in),
    .scale      (scale[2]),
    .bias       (bias[2]),
    .frac_shift (frac_shift),
    .q          (pix_out.chan2_out)
  );
endmodule

// ===== hdl/pnq_ctrl.sv =====
module pnq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output pnq_pkg::pnq_ctrl_t ctrl
);
  import pnq_pkg::*;

  logic [NUM_STAGES-1:0] valid;

  // A stage may load when it is empty or when its content moves on this cycle.
  always_comb begin
    ctrl.en[NUM_STAGES-1] = !valid[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ctrl.en[i] = !valid[i] || ctrl.en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctrl.en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ctrl.en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign in_ready  = ctrl.en[0];
  assign out_valid = valid[NUM_STAGES-1];
endmodule

// ===== hdl/pnq_lane.sv =====
module pnq_lane #(
  parameter int COEF_FRAC_BITS = pnq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  pnq_pkg::pnq_ctrl_t               ctrl,
  input  logic [pnq_pkg::PIX_W-1:0]        pix,
  input  logic [pnq_pkg::SCALE_W-1:0]      scale,
  input  logic signed [pnq_pkg::BIAS_W-1:0] bias,
  input  logic [pnq_pkg::SHIFT_W-1:0]      frac_shift,
  output logic signed [pnq_pkg::OUT_W-1:0] q
);
  import pnq_pkg::*;

  localparam int PROD_W = PIX_W + SCALE_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int MAG_W  = ACC_W + (2 ** SHIFT_W) - 1;
  localparam int IP_W   = MAG_W - COEF_FRAC_BITS;

  logic [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [MAG_W-1:0] scaled;
  logic [MAG_W-1:0]        mag;
  logic                    neg_q;
  logic [IP_W-1:0]         ip_q;
  logic signed [OUT_W-1:0] sat;

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      prod_q <= PROD_W'(pix) * PROD_W'(scale);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      acc_q <= signed'(ACC_W'(prod_q)) + ACC_W'(bias);
    end
  end

  // Truncation toward zero: take the integer part of the magnitude.
  always_comb begin
    scaled = MAG_W'(acc_q) <<< frac_shift;
    mag    = scaled[MAG_W-1] ? MAG_W'(-scaled) : MAG_W'(scaled);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      neg_q <= scaled[MAG_W-1];
      ip_q  <= mag[MAG_W-1:COEF_FRAC_BITS];
    end
  end

  always_comb begin
    if (neg_q) begin
      sat = (ip_q >= IP_W'(128)) ? -8'sd128 : signed'(~ip_q[OUT_W-1:0] + 8'd1);
    end else begin
      sat = (ip_q >= IP_W'(127)) ? 8'sd127 : signed'(ip_q[OUT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      q <= sat;
    end
  end
endmodule

// ===== hdl/pnq_checker.sv =====
module pnq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [pnq_pkg::OUT_W-1:0] chan0_out,
  input logic signed [pnq_pkg::OUT_W-1:0] chan1_out,
  input logic signed [pnq_pkg::OUT_W-1:0] chan2_out
);
  import pnq_pkg::*;

  localparam int CNT_W = $clog2(NUM_STAGES + 1);

  logic [CNT_W-1:0] in_flight;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chan0_out)
      && $stable(chan1_out) && $stable(chan2_out))
    else $error("stalled result changed or vanished");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CNT_W'(NUM_STAGES))
    else $error("more requests in flight than pipeline stages");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    in_flight == '0 |-> !out_valid)
    else $error("result shown with no request in flight");

  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while the output drains");
endmodule

bind pixel_normalize_quantize_int8_core pnq_checker u_pnq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .chan0_out (pix_out.chan0_out),
  .chan1_out (pix_out.chan1_out),
  .chan2_out (pix_out.chan2_out)
);
